// ===== sv/clkse_pkg.sv =====
package clkse_pkg;

	localparam int YearW = 7;
	localparam int MonthW = 4;
	localparam int DayW = 5;
	localparam int HourW = 5;
	localparam int MinuteW = 6;
	localparam int SecondW = 6;
	localparam int CursorW = 3;
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 7;

	// operation codes
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_NEXT = 2'd1;
	localparam logic [1:0] OP_INC = 2'd2;
	localparam logic [1:0] OP_DEC = 2'd3;

	// cursor positions
	localparam logic [CursorW-1:0] FLD_YEAR = 3'd0;
	localparam logic [CursorW-1:0] FLD_MONTH = 3'd1;
	localparam logic [CursorW-1:0] FLD_DAY = 3'd2;
	localparam logic [CursorW-1:0] FLD_HOUR = 3'd3;
	localparam logic [CursorW-1:0] FLD_MINUTE = 3'd4;
	localparam logic [CursorW-1:0] FLD_SECOND = 3'd5;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_YEAR_FLOOR = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_YEAR_CEILING = 1'b1;

	localparam logic [YearW-1:0] YEAR_CEILING_RST = 7'd99;

	typedef struct packed {
		logic [1:0] op;
		logic pressed;
		logic long_press;
		logic first_repeat;
		logic clicked;
		logic [YearW-1:0] load_year;
		logic [MonthW-1:0] load_month;
		logic [DayW-1:0] load_day;
		logic [HourW-1:0] load_hour;
		logic [MinuteW-1:0] load_minute;
		logic [SecondW-1:0] load_second;
	} in_item_t;

	typedef struct packed {
		logic [CursorW-1:0] cursor;
		logic [YearW-1:0] year_out;
		logic [MonthW-1:0] month_out;
		logic [DayW-1:0] day_out;
		logic [HourW-1:0] hour_out;
		logic [MinuteW-1:0] minute_out;
		logic [SecondW-1:0] second_out;
		logic commit;
		logic exit_request;
		logic changed;
	} out_item_t;

	typedef struct packed {
		logic [CursorW-1:0] cursor;
		logic [YearW-1:0] year;
		logic [MonthW-1:0] month;
		logic [DayW-1:0] day;
		logic [HourW-1:0] hour;
		logic [MinuteW-1:0] minute;
		logic [SecondW-1:0] second;
		logic exit_pending;
	} edit_state_t;

	// remainder by ten through a reciprocal multiply, exact for 8-bit values
	function automatic logic [3:0] mod10(input logic [7:0] x);
		logic [15:0] prod;
		logic [4:0] quo;
		logic [7:0] rem;
		prod = {8'd0, x} * 16'd205;
		quo = prod[15:11];
		rem = x - ({3'd0, quo} * 8'd10);
		return rem[3:0];
	endfunction

	function automatic logic [6:0] floor10(input logic [6:0] x);
		return x - {3'd0, mod10({1'b0, x})};
	endfunction

	// year offset counts from 2000, so only offset 100 breaks the four-year rule
	function automatic logic [DayW-1:0] month_days(input logic [YearW-1:0] yoff,
			input logic [MonthW-1:0] mon);
		logic leap;
		logic [DayW-1:0] d;
		leap = (yoff[1:0] == 2'd0) && (yoff != 7'd100);
		case (mon)
			4'd2: d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

// ===== sv/clkse_update.sv =====
module clkse_update (
	input clkse_pkg::edit_state_t st,
	input clkse_pkg::in_item_t item,
	input logic [clkse_pkg::YearW-1:0] year_floor,
	input logic [clkse_pkg::YearW-1:0] year_ceiling,
	output clkse_pkg::edit_state_t nxt,
	output clkse_pkg::out_item_t res
);
	import clkse_pkg::*;

	logic commit;
	logic exit_req;
	logic changed;
	logic [6:0] cur_v;
	logic [6:0] lo;
	logic [6:0] hi;
	logic signed [8:0] t_inc;
	logic signed [8:0] t_dec;
	logic signed [8:0] t_new;
	logic [DayW-1:0] month_end;
	logic is_min;
	logic is_sec;

	assign month_end = month_days(st.year, st.month);
	assign is_min = (st.cursor == FLD_MINUTE);
	assign is_sec = (st.cursor == FLD_SECOND);

	always_comb begin
		case (st.cursor)
			FLD_YEAR: begin
				cur_v = st.year;
				lo = year_floor;
				hi = year_ceiling;
			end
			FLD_MONTH: begin
				cur_v = {3'd0, st.month};
				lo = 7'd1;
				hi = 7'd12;
			end
			FLD_DAY: begin
				cur_v = {2'd0, st.day};
				lo = 7'd1;
				hi = {2'd0, month_end};
			end
			FLD_HOUR: begin
				cur_v = {2'd0, st.hour};
				lo = 7'd0;
				hi = 7'd23;
			end
			FLD_MINUTE: begin
				cur_v = {1'b0, st.minute};
				lo = 7'd0;
				hi = 7'd59;
			end
			default: begin
				cur_v = {1'b0, st.second};
				lo = 7'd0;
				hi = 7'd59;
			end
		endcase
	end

	always_comb begin
		t_inc = $signed({2'b00, cur_v}) + 9'sd1;
		if (is_min && item.long_press && mod10(t_inc[7:0]) == 4'd1) begin
			t_inc = t_inc + 9'sd9;
		end
		if (is_sec) begin
			t_inc = t_inc + 9'sd9;
		end
		if (t_inc > $signed({2'b00, hi})) begin
			t_inc = $signed({2'b00, lo});
		end

		t_dec = $signed({2'b00, cur_v}) - 9'sd1;
		// a result of minus one must not count as ending in nine
		if (is_min && item.long_press && !t_dec[8] && mod10(t_dec[7:0]) == 4'd9) begin
			t_dec = t_dec - 9'sd9;
		end
		if (is_sec) begin
			t_dec = t_dec - 9'sd9;
		end
		if (t_dec < $signed({2'b00, lo})) begin
			t_dec = $signed({2'b00, hi});
		end
		if (is_sec && t_dec == $signed({2'b00, hi})) begin
			t_dec = $signed({2'b00, floor10(hi)});
		end

		t_new = (item.op == OP_INC) ? t_inc : t_dec;
	end

	always_comb begin
		nxt = st;
		commit = 1'b0;
		exit_req = 1'b0;
		changed = 1'b0;
		if (item.op == OP_LOAD) begin
			nxt.cursor = FLD_YEAR;
			nxt.year = item.load_year;
			nxt.month = item.load_month;
			nxt.day = item.load_day;
			nxt.hour = item.load_hour;
			nxt.minute = item.load_minute;
			nxt.second = SecondW'(floor10({1'b0, item.load_second}));
			changed = 1'b1;
		end else if (st.exit_pending) begin
			if (item.op == OP_NEXT && item.clicked) begin
				nxt.exit_pending = 1'b0;
				exit_req = 1'b1;
			end
		end else if (item.op == OP_NEXT) begin
			if (item.pressed) begin
				if (item.long_press) begin
					exit_req = item.first_repeat;
				end else if (st.cursor >= FLD_SECOND) begin
					commit = 1'b1;
					nxt.exit_pending = 1'b1;
				end else begin
					nxt.cursor = st.cursor + 3'd1;
					if (st.cursor == FLD_MONTH && st.day > month_end) begin
						nxt.day = month_end;
					end
					changed = 1'b1;
				end
			end
		end else if (item.pressed && st.cursor <= FLD_SECOND) begin
			case (st.cursor)
				FLD_YEAR: nxt.year = t_new[YearW-1:0];
				FLD_MONTH: nxt.month = t_new[MonthW-1:0];
				FLD_DAY: nxt.day = t_new[DayW-1:0];
				FLD_HOUR: nxt.hour = t_new[HourW-1:0];
				FLD_MINUTE: nxt.minute = t_new[MinuteW-1:0];
				default: nxt.second = t_new[SecondW-1:0];
			endcase
			changed = 1'b1;
		end
	end

	always_comb begin
		res.cursor = nxt.cursor;
		res.year_out = nxt.year;
		res.month_out = nxt.month;
		res.day_out = nxt.day;
		res.hour_out = nxt.hour;
		res.minute_out = nxt.minute;
		res.second_out = nxt.second;
		res.commit = commit;
		res.exit_request = exit_req;
		res.changed = changed;
	end

endmodule

// ===== sv/clock_set_field_editor.sv =====
// Clock-setting editor for a three-button clock. Every accepted item (load, next,
// increment or decrement event) yields exactly one result carrying the cursor, all six
// edited fields and the commit, exit_request and changed flags. An item is captured in
// an input register and updates the edit state as its result enters the output
// register; one item can be accepted every cycle while results are taken; a result
// held by out_stall lets one more item into the input register, after which in_stall
// rises until the result leaves. year_floor and year_ceiling bound the year field;
// the user must write them only while idle; the block does not enforce it.
module clock_set_field_editor (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input clkse_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output clkse_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic [clkse_pkg::CfgIdxW-1:0] cfg_index,
	input logic [clkse_pkg::CfgDataW-1:0] cfg_data
);
	import clkse_pkg::*;

	logic valid_s1;
	in_item_t item_s1;
	logic out_valid_q;
	out_item_t out_data_q;
	logic [YearW-1:0] year_floor_q;
	logic [YearW-1:0] year_ceiling_q;
	edit_state_t state_q;
	edit_state_t state_nxt;
	out_item_t res;
	logic adv;
	logic in_acc;

	// item in the input register moves on when the output register is free
	assign adv = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	clkse_update u_update (
		.st(state_q),
		.item(item_s1),
		.year_floor(year_floor_q),
		.year_ceiling(year_ceiling_q),
		.nxt(state_nxt),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_floor_q <= '0;
			year_ceiling_q <= YEAR_CEILING_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_YEAR_FLOOR: year_floor_q <= cfg_data[YearW-1:0];
				CFG_YEAR_CEILING: year_ceiling_q <= cfg_data[YearW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cursor <= FLD_YEAR;
			state_q.year <= '0;
			state_q.month <= MonthW'(1);
			state_q.day <= DayW'(1);
			state_q.hour <= '0;
			state_q.minute <= '0;
			state_q.second <= '0;
			state_q.exit_pending <= 1'b0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= res;
		end
	end

`ifndef SYNTHESIS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.cursor <= FLD_SECOND)
		else $error("cursor beyond seconds field");

	a_commit_at_seconds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.commit) |-> (out_data.cursor == FLD_SECOND &&
			!out_data.exit_request && !out_data.changed))
		else $error("commit raised away from seconds field");

	a_commit_arms_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.commit) |=> state_q.exit_pending)
		else $error("commit did not arm pending exit");

	a_seconds_tens: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mod10({2'd0, out_data.second_out}) == 4'd0)
		else $error("seconds not a multiple of ten");

	a_pending_blocks_edit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && state_q.exit_pending && item_s1.op != OP_LOAD) |=>
			(state_q.cursor == $past(state_q.cursor) && state_q.second == $past(state_q.second)))
		else $error("field changed while exit pending");
`endif

endmodule

// ===== dv/clock_set_field_editor_tb.sv =====
module clock_set_field_editor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import clkse_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int DIR_ROWS = 27;
	localparam int RAND_PER_PHASE = 225;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	clock_set_field_editor dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// editor state as the block should hold it
	logic [CursorW-1:0] cur_fld = FLD_YEAR;
	logic [YearW-1:0] ed_year = '0;
	logic [MonthW-1:0] ed_month = 4'd1;
	logic [DayW-1:0] ed_day = 5'd1;
	logic [HourW-1:0] ed_hour = '0;
	logic [MinuteW-1:0] ed_minute = '0;
	logic [SecondW-1:0] ed_second = '0;
	logic exit_armed = 1'b0;
	logic [YearW-1:0] yr_floor = '0;
	logic [YearW-1:0] yr_ceil = YEAR_CEILING_RST;

	out_item_t edit_results_due [$];
	out_item_t due_now;
	int errors = 0;
	int results_seen = 0;
	int quiet = 0;
	int src_idle_pct = 0;
	int rcv_idle_pct = 0;

	// btn is {pressed, long_press, first_repeat, clicked}
	typedef struct packed {
		logic [1:0] op;
		logic [3:0] btn;
		logic [YearW-1:0] y;
		logic [MonthW-1:0] mo;
		logic [DayW-1:0] d;
		logic [HourW-1:0] h;
		logic [MinuteW-1:0] mi;
		logic [SecondW-1:0] s;
		logic typed;
		out_item_t want;
	} dir_row_t;

	dir_row_t dir_table [DIR_ROWS] = '{
		// year wraps down to the ceiling and back up to the floor
		'{OP_DEC, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b1,
			{FLD_YEAR, 7'd99, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b1}},
		'{OP_INC, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b1,
			{FLD_YEAR, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b1}},
		// all-ones load, seconds floored, out-of-range values kept
		'{OP_LOAD, 4'b1111, 127, 15, 31, 31, 63, 63, 1'b1,
			{FLD_YEAR, 7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd60, 1'b0, 1'b0, 1'b1}},
		'{OP_INC, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_NEXT, 4'b0011, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_NEXT, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_INC, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_INC, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		// long press repeat does nothing
		'{OP_NEXT, 4'b1100, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		// day 31 clamped to leap february
		'{OP_NEXT, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_INC, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_DEC, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_NEXT, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_DEC, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_NEXT, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		// minute tens jumps on long press
		'{OP_INC, 4'b1100, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_INC, 4'b1100, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_DEC, 4'b1100, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_DEC, 4'b1100, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_NEXT, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_INC, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_DEC, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		// commit arms the exit, then only load and a click get through
		'{OP_NEXT, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_LOAD, 4'b0000, 0, 1, 1, 0, 0, 9, 1'b0, '0},
		'{OP_NEXT, 4'b1000, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_NEXT, 4'b0001, 0, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_NEXT, 4'b1110, 0, 0, 0, 0, 0, 0, 1'b0, '0}
	};

	function automatic int days_in_month(input logic [YearW-1:0] yoff,
			input logic [MonthW-1:0] mon);
		int y;
		y = int'(yoff) + 2000;
		if (mon == 4'd2)
			return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
		if (mon == 4'd4 || mon == 4'd6 || mon == 4'd9 || mon == 4'd11)
			return 30;
		return 31;
	endfunction

	function automatic out_item_t predict_edit(input in_item_t it);
		out_item_t r;
		int v;
		int lo;
		int hi;
		r = '0;
		if (it.op == OP_LOAD) begin
			cur_fld = FLD_YEAR;
			ed_year = it.load_year;
			ed_month = it.load_month;
			ed_day = it.load_day;
			ed_hour = it.load_hour;
			ed_minute = it.load_minute;
			ed_second = SecondW'((int'(it.load_second) / 10) * 10);
			r.changed = 1'b1;
		end else if (exit_armed) begin
			if (it.op == OP_NEXT && it.clicked) begin
				exit_armed = 1'b0;
				r.exit_request = 1'b1;
			end
		end else if (it.op == OP_NEXT) begin
			if (it.pressed) begin
				if (it.long_press) begin
					r.exit_request = it.first_repeat;
				end else if (cur_fld >= FLD_SECOND) begin
					r.commit = 1'b1;
					exit_armed = 1'b1;
				end else begin
					cur_fld = cur_fld + 3'd1;
					if (cur_fld == FLD_DAY && int'(ed_day) > days_in_month(ed_year, ed_month))
						ed_day = DayW'(days_in_month(ed_year, ed_month));
					r.changed = 1'b1;
				end
			end
		end else if (it.pressed) begin
			case (cur_fld)
				FLD_YEAR: begin
					v = int'(ed_year); lo = int'(yr_floor); hi = int'(yr_ceil);
				end
				FLD_MONTH: begin
					v = int'(ed_month); lo = 1; hi = 12;
				end
				FLD_DAY: begin
					v = int'(ed_day); lo = 1; hi = days_in_month(ed_year, ed_month);
				end
				FLD_HOUR: begin
					v = int'(ed_hour); lo = 0; hi = 23;
				end
				FLD_MINUTE: begin
					v = int'(ed_minute); lo = 0; hi = 59;
				end
				default: begin
					v = int'(ed_second); lo = 0; hi = 59;
				end
			endcase
			if (it.op == OP_INC) begin
				v = v + 1;
				if (cur_fld == FLD_MINUTE && it.long_press && v % 10 == 1)
					v = v + 9;
				if (cur_fld == FLD_SECOND)
					v = v + 9;
				if (v > hi)
					v = lo;
			end else begin
				v = v - 1;
				if (cur_fld == FLD_MINUTE && it.long_press && v >= 0 && v % 10 == 9)
					v = v - 9;
				if (cur_fld == FLD_SECOND)
					v = v - 9;
				if (v < lo)
					v = hi;
				if (cur_fld == FLD_SECOND && v == hi)
					v = (hi / 10) * 10;
			end
			case (cur_fld)
				FLD_YEAR: ed_year = YearW'(v);
				FLD_MONTH: ed_month = MonthW'(v);
				FLD_DAY: ed_day = DayW'(v);
				FLD_HOUR: ed_hour = HourW'(v);
				FLD_MINUTE: ed_minute = MinuteW'(v);
				default: ed_second = SecondW'(v);
			endcase
			r.changed = 1'b1;
		end
		r.cursor = cur_fld;
		r.year_out = ed_year;
		r.month_out = ed_month;
		r.day_out = ed_day;
		r.hour_out = ed_hour;
		r.minute_out = ed_minute;
		r.second_out = ed_second;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		$display("edit result %0d: %s", results_seen, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_YEAR_FLOOR)
			yr_floor = val;
		else
			yr_ceil = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// drives one item, waits for it to be taken and queues what it should produce
	task automatic push_item(input in_item_t it, input logic typed, input out_item_t want);
		out_item_t pred;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		pred = predict_edit(it);
		edit_results_due.push_back(typed ? want : pred);
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (edit_results_due.size() == 0) begin
				report_mismatch("result with no item outstanding");
			end else begin
				due_now = edit_results_due.pop_front();
				check_field("cursor", int'(out_data.cursor), int'(due_now.cursor));
				check_field("year", int'(out_data.year_out), int'(due_now.year_out));
				check_field("month", int'(out_data.month_out), int'(due_now.month_out));
				check_field("day", int'(out_data.day_out), int'(due_now.day_out));
				check_field("hour", int'(out_data.hour_out), int'(due_now.hour_out));
				check_field("minute", int'(out_data.minute_out), int'(due_now.minute_out));
				check_field("second", int'(out_data.second_out), int'(due_now.second_out));
				check_field("commit", int'(out_data.commit), int'(due_now.commit));
				check_field("exit_request", int'(out_data.exit_request),
					int'(due_now.exit_request));
				check_field("changed", int'(out_data.changed), int'(due_now.changed));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("timeout after %0d quiet cycles, %0d results outstanding",
				quiet, edit_results_due.size());
			$display("clock_set_field_editor verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		in_item_t it;
		logic [63:0] raw;
		int k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 12;
					rcv_idle_pct = 82;
					write_reg(CFG_YEAR_FLOOR, 7'd0);
					write_reg(CFG_YEAR_CEILING, 7'd99);
				end
				1: begin
					// floor above ceiling
					src_idle_pct = 82;
					rcv_idle_pct = 12;
					write_reg(CFG_YEAR_FLOOR, 7'd99);
					write_reg(CFG_YEAR_CEILING, 7'd0);
				end
				default: begin
					src_idle_pct = 0;
					rcv_idle_pct = 0;
					write_reg(CFG_YEAR_FLOOR, CfgDataW'($urandom_range(0, 99)));
					write_reg(CFG_YEAR_CEILING, CfgDataW'($urandom_range(0, 99)));
				end
			endcase

			if (ph == 0) begin
				for (int i = 0; i < DIR_ROWS; i++) begin
					it = '0;
					it.op = dir_table[i].op;
					{it.pressed, it.long_press, it.first_repeat, it.clicked} = dir_table[i].btn;
					it.load_year = dir_table[i].y;
					it.load_month = dir_table[i].mo;
					it.load_day = dir_table[i].d;
					it.load_hour = dir_table[i].h;
					it.load_minute = dir_table[i].mi;
					it.load_second = dir_table[i].s;
					push_item(it, dir_table[i].typed, dir_table[i].want);
				end
			end

			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				raw = {$urandom, $urandom};
				it = raw[$bits(in_item_t)-1:0];
				k = $urandom_range(0, 99);
				if (k < 4) begin
					it.op = OP_LOAD;
					// mostly fields in their usual ranges, sometimes raw bits
					if ($urandom_range(0, 3) != 0) begin
						it.load_year = YearW'($urandom_range(0, 99));
						it.load_month = MonthW'($urandom_range(1, 12));
						it.load_day = DayW'($urandom_range(1, 31));
						it.load_hour = HourW'($urandom_range(0, 23));
						it.load_minute = MinuteW'($urandom_range(0, 59));
						it.load_second = SecondW'($urandom_range(0, 59));
					end
				end else if (k < 34) begin
					it.op = OP_NEXT;
					it.pressed = ($urandom_range(0, 9) != 0);
					it.long_press = ($urandom_range(0, 5) == 0);
				end else if (k < 94) begin
					it.op = $urandom_range(0, 1) ? OP_INC : OP_DEC;
					it.pressed = ($urandom_range(0, 9) != 0);
				end
				push_item(it, 1'b0, '0);
			end
			@(negedge clk);
			in_valid <= 1'b0;
			while (edit_results_due.size() != 0)
				@(posedge clk);
			repeat (4) @(posedge clk);
		end

		if (errors == 0)
			$display("clock_set_field_editor verification clean");
		else
			$display("clock_set_field_editor verification failed");
		$finish;
	end

endmodule
